// ----- sv/rect_subtract_macros.svh -----
// Assertion macros shared by the rect_subtract checker.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef RECT_SUBTRACT_MACROS_SVH
`define RECT_SUBTRACT_MACROS_SVH

// An implication that is checked on every clock edge outside reset.
`define RS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold on the cycle after reset is seen.
`define RS_ASSERT_RST(label, cons, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

// ----- sv/rs_pkg.sv -----
// Package for the rectangle subtraction block: defaults, queue depth and
// the status bundle that passes from the job queue to the piece emitter.
`default_nettype none
package rs_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int NUM_PIECES     = 4;

    typedef struct packed {
        logic not_empty;
        logic no_credit;
    } t_q_status;

endpackage
`default_nettype wire

// ----- sv/rs_front.sv -----
// Front end of the rectangle subtraction block: registers the intersection
// of A and B, then forms the four candidate strips and their keep mask.
// Depends on rs_pkg.
`default_nettype none
module rs_front import rs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int PW        = 4 * COORD_BITS,
    localparam int JOB_W     = NUM_PIECES * PW + NUM_PIECES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic signed [COORD_BITS-1:0] i_a_x,
    input  logic signed [COORD_BITS-1:0] i_a_y,
    input  logic        [COORD_BITS-2:0] i_a_w,
    input  logic        [COORD_BITS-2:0] i_a_h,
    input  logic signed [COORD_BITS-1:0] i_b_x,
    input  logic signed [COORD_BITS-1:0] i_b_y,
    input  logic        [COORD_BITS-2:0] i_b_w,
    input  logic        [COORD_BITS-2:0] i_b_h,
    output logic                         o_push,
    output logic        [JOB_W-1:0]      o_job
);

    localparam int W = COORD_BITS + 2;

    logic signed [W-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    logic signed [W-1:0] a_r, a_b, b_r, b_b;

    logic                r_v1;
    logic signed [W-1:0] r_ax, r_ay, r_aw, r_ah, r_lx, r_rx, r_ty, r_by;

    logic signed [W-1:0]    px [NUM_PIECES];
    logic signed [W-1:0]    py [NUM_PIECES];
    logic signed [W-1:0]    pw [NUM_PIECES];
    logic signed [W-1:0]    ph [NUM_PIECES];
    logic [NUM_PIECES-1:0]  keep;
    logic                   overlap;
    logic signed [W-1:0]    iw;

    always_comb begin
        ax  = {{(W-COORD_BITS){i_a_x[COORD_BITS-1]}}, i_a_x};
        ay  = {{(W-COORD_BITS){i_a_y[COORD_BITS-1]}}, i_a_y};
        bx  = {{(W-COORD_BITS){i_b_x[COORD_BITS-1]}}, i_b_x};
        by  = {{(W-COORD_BITS){i_b_y[COORD_BITS-1]}}, i_b_y};
        aw  = {{(W-COORD_BITS+1){1'b0}}, i_a_w};
        ah  = {{(W-COORD_BITS+1){1'b0}}, i_a_h};
        bw  = {{(W-COORD_BITS+1){1'b0}}, i_b_w};
        bh  = {{(W-COORD_BITS+1){1'b0}}, i_b_h};
        a_r = ax + aw - W'(1);
        a_b = ay + ah - W'(1);
        b_r = bx + bw - W'(1);
        b_b = by + bh - W'(1);
    end

    // Stage one: inclusive edges of the intersection.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_take;
        end
        if (i_take) begin
            r_ax <= ax;
            r_ay <= ay;
            r_aw <= aw;
            r_ah <= ah;
            r_lx <= (ax > bx) ? ax : bx;
            r_rx <= (a_r < b_r) ? a_r : b_r;
            r_ty <= (ay > by) ? ay : by;
            r_by <= (a_b < b_b) ? a_b : b_b;
        end
    end

    // Stage two: strips left, top, right, bottom; all of A if no overlap.
    always_comb begin
        overlap = (r_lx <= r_rx) && (r_ty <= r_by);
        iw      = r_rx - r_lx + W'(1);
        if (overlap) begin
            px[0] = r_ax;             py[0] = r_ay;
            pw[0] = r_lx - r_ax;      ph[0] = r_ah;
            px[1] = r_lx;             py[1] = r_ay;
            pw[1] = iw;               ph[1] = r_ty - r_ay;
            px[2] = r_rx + W'(1);     py[2] = r_ay;
            pw[2] = r_ax + r_aw - (r_rx + W'(1));
            ph[2] = r_ah;
            px[3] = r_lx;             py[3] = r_by + W'(1);
            pw[3] = iw;
            ph[3] = r_ay + r_ah - (r_by + W'(1));
        end else begin
            px[0] = r_ax;             py[0] = r_ay;
            pw[0] = r_aw;             ph[0] = r_ah;
            for (int k = 1; k < NUM_PIECES; k++) begin
                px[k] = '0;
                py[k] = '0;
                pw[k] = '0;
                ph[k] = '0;
            end
        end
        for (int k = 0; k < NUM_PIECES; k++) begin
            keep[k] = !pw[k][W-1] && (pw[k] != '0) && !ph[k][W-1] && (ph[k] != '0);
            o_job[NUM_PIECES + k*PW +: PW] = {px[k][COORD_BITS:0], py[k][COORD_BITS:0],
                                              pw[k][COORD_BITS-2:0], ph[k][COORD_BITS-2:0]};
        end
        o_job[NUM_PIECES-1:0] = keep;
    end

    assign o_push = r_v1;

endmodule
`default_nettype wire

// ----- sv/rs_queue.sv -----
// Job queue between the front end and the emitter, with a credit count
// that covers the item still in the front end. Depends on rs_pkg.
`default_nettype none
module rs_queue import rs_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output t_q_status         o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr, r_rd;
    logic [CW-1:0]     r_count, r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_used  <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
            r_used  <= r_used + CW'(i_take) - CW'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data             = r_mem[r_rd];
    assign o_status.not_empty = (r_count != '0);
    assign o_status.no_credit = (r_used == CW'(DEPTH));

endmodule
`default_nettype wire

// ----- sv/rs_back.sv -----
// Piece emitter: takes one job at a time from the queue and, while it holds a job,
// drives one result per cycle from its output registers. Depends on rs_pkg.
`default_nettype none
module rs_back import rs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int PW        = 4 * COORD_BITS,
    localparam int JOB_W     = NUM_PIECES * PW + NUM_PIECES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_q_status                    i_status,
    input  logic        [JOB_W-1:0]      i_job,
    output logic                         o_pop,
    output logic                         o_strobe,
    output logic signed [COORD_BITS:0]   o_piece_x,
    output logic signed [COORD_BITS:0]   o_piece_y,
    output logic        [COORD_BITS-2:0] o_piece_w,
    output logic        [COORD_BITS-2:0] o_piece_h,
    output logic                         o_present,
    output logic                         o_last
);

    localparam int SW = $clog2(NUM_PIECES);

    logic                         r_act;
    logic [NUM_PIECES-1:0]        r_rem;
    logic [NUM_PIECES*PW-1:0]     r_job;
    logic                         r_strobe, r_present, r_last;
    logic signed [COORD_BITS:0]   r_x, r_y;
    logic        [COORD_BITS-2:0] r_w, r_h;

    logic [SW-1:0]         sel;
    logic [PW-1:0]         piece;
    logic [NUM_PIECES-1:0] n_rem;
    logic                  fin;

    always_comb begin
        sel = '0;
        for (int k = NUM_PIECES - 1; k >= 0; k--) begin
            if (r_rem[k]) begin
                sel = SW'(k);
            end
        end
        piece = r_job[sel*PW +: PW];
        n_rem = r_rem & ~(NUM_PIECES'(1) << sel);
        fin   = r_act && (n_rem == '0);
        o_pop = i_status.not_empty && (!r_act || fin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_act;
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (fin) begin
                r_act <= 1'b0;
            end
        end
        if (o_pop) begin
            r_rem <= i_job[NUM_PIECES-1:0];
            r_job <= i_job[JOB_W-1:NUM_PIECES];
        end else if (r_act) begin
            r_rem <= n_rem;
        end
        if (r_act) begin
            r_present <= (r_rem != '0);
            r_last    <= (n_rem == '0);
            if (r_rem != '0) begin
                {r_x, r_y, r_w, r_h} <= piece;
            end else begin
                {r_x, r_y, r_w, r_h} <= '0;
            end
        end
    end

    assign o_strobe  = r_strobe;
    assign o_piece_x = r_x;
    assign o_piece_y = r_y;
    assign o_piece_w = r_w;
    assign o_piece_h = r_h;
    assign o_present = r_present;
    assign o_last    = r_last;

endmodule
`default_nettype wire

// ----- sv/rect_subtract.sv -----
// Top level of the rectangle subtraction block: front end, job queue and
// piece emitter. Depends on rs_pkg, rs_front, rs_queue and rs_back.
//
//  Channel   Handshake             Payload
//  -------   -------------------   -------------------------------------------
//  command   start / busy          i_a_x i_a_y i_a_w i_a_h i_b_x i_b_y i_b_w i_b_h
//  result    o_strobe (no stall)   o_piece_x o_piece_y o_piece_w o_piece_h
//                                  o_present o_last
//
// A command transfer takes place on a rising edge where start is high and busy is low.
// Each command gives one to four results, one per clock cycle; the emitter starts the
// next job with no gap when one waits in the queue.
// A command passes the front-end registers, the job queue and the emitter in order.
// Reset is synchronous and active low; it empties the queue and clears the strobe.
// Busy rises only when QDEPTH commands are held between the ports and not yet started
// by the emitter; the receiver cannot stall, so results never wait.
`default_nettype none
module rect_subtract import rs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int QDEPTH     = QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_a_x,
    input  logic signed [COORD_BITS-1:0] i_a_y,
    input  logic        [COORD_BITS-2:0] i_a_w,
    input  logic        [COORD_BITS-2:0] i_a_h,
    input  logic signed [COORD_BITS-1:0] i_b_x,
    input  logic signed [COORD_BITS-1:0] i_b_y,
    input  logic        [COORD_BITS-2:0] i_b_w,
    input  logic        [COORD_BITS-2:0] i_b_h,
    output logic                         o_strobe,
    output logic signed [COORD_BITS:0]   o_piece_x,
    output logic signed [COORD_BITS:0]   o_piece_y,
    output logic        [COORD_BITS-2:0] o_piece_w,
    output logic        [COORD_BITS-2:0] o_piece_h,
    output logic                         o_present,
    output logic                         o_last
);

    // One job is the four candidate strips plus a mask of those worth keeping.
    localparam int JOB_W = NUM_PIECES * 4 * COORD_BITS + NUM_PIECES;

    logic             take;
    logic             push;
    logic             pop;
    logic [JOB_W-1:0] front_job;
    logic [JOB_W-1:0] head_job;
    t_q_status        q_status;

    // The credit count in the queue also covers the command in the front end,
    // so a command is only taken when a queue slot is certain to be free.
    assign busy = q_status.no_credit;
    assign take = start && !busy;

    rs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_a_w   (i_a_w),
        .i_a_h   (i_a_h),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_b_w   (i_b_w),
        .i_b_h   (i_b_h),
        .o_push  (push),
        .o_job   (front_job)
    );

    rs_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_push   (push),
        .i_data   (front_job),
        .i_pop    (pop),
        .o_data   (head_job),
        .o_status (q_status)
    );

    // The emitter loads the next job in the same cycle as it sends the last
    // piece of the current one, so results can follow each other without a gap.
    rs_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_status  (q_status),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_strobe  (o_strobe),
        .o_piece_x (o_piece_x),
        .o_piece_y (o_piece_y),
        .o_piece_w (o_piece_w),
        .o_piece_h (o_piece_h),
        .o_present (o_present),
        .o_last    (o_last)
    );

endmodule
`default_nettype wire

// ----- sv/rect_subtract_checker.sv -----
// Port-level checks for rect_subtract and the bind that attaches them.
// Depends on rs_pkg and rect_subtract_macros.svh.
`default_nettype none
`include "rect_subtract_macros.svh"
module rect_subtract_checker import rs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  busy,
    input wire logic                  o_strobe,
    input wire logic [COORD_BITS-2:0] o_piece_w,
    input wire logic [COORD_BITS-2:0] o_piece_h,
    input wire logic                  o_present,
    input wire logic                  o_last
);

    `RS_ASSERT_RST(a_reset_quiet, !o_strobe && !busy, "strobe or busy set after reset")
    `RS_ASSERT_IMP(a_empty_alone, o_strobe && !o_present, o_last && o_piece_w == '0 && o_piece_h == '0, "empty result not last or not zero")
    `RS_ASSERT_IMP(a_piece_size, o_strobe && o_present, o_piece_w != '0 && o_piece_h != '0, "piece of zero size")
    `RS_ASSERT_IMP(a_run_cont, o_strobe && $past(o_strobe) && !$past(o_last), o_present, "empty result inside a run")

endmodule

bind rect_subtract rect_subtract_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);
`default_nettype wire
